>>> hdl/lir_pkg.sv
// shared types and constants for the linear interpolation resampler
package lir_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int MAX_OUTPUTS = 64;
  localparam int CNT_W       = $clog2(MAX_OUTPUTS);

  localparam int SAMPLE_W    = 32;
  localparam int PHASE_W     = 32;
  localparam int STEP_W      = 21;
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int PROD_W      = DIFF_W + FRAC_BITS + 1;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = STEP_W;

  localparam logic [PHASE_W-1:0] ONE_PERIOD = PHASE_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(65536);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE = 1'b1;

  // item opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef struct packed {
    logic capture;    // latch the incoming samples
    logic flush;      // clear phase and history
    logic diff;       // form cur - prev per channel
    logic mul;        // frac times difference
    logic emit;       // load output register and step the phase
    logic emit_last;  // final output of this item
    logic update;     // drop one period, move cur into history
  } cmd_t;

  typedef struct packed {
    logic phase_int_zero;  // integer part of phase is zero
    logic next_int_zero;   // integer part of phase + step is zero
  } status_t;

endpackage

>>> hdl/lir_datapath.sv
// datapath: config registers, phase, history, multiplier and output register
module lir_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [lir_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lir_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [lir_pkg::SAMPLE_W-1:0] left_in,
  input  logic signed [lir_pkg::SAMPLE_W-1:0] right_in,
  input  lir_pkg::cmd_t                    cmd,
  output lir_pkg::status_t                 status,
  output logic signed [lir_pkg::SAMPLE_W-1:0] left_out,
  output logic signed [lir_pkg::SAMPLE_W-1:0] right_out,
  output logic                             last_of_run
);

  logic [lir_pkg::STEP_W-1:0]            phase_step;
  logic                                  stereo_mode;
  logic [lir_pkg::PHASE_W-1:0]           phase;
  logic [lir_pkg::PHASE_W-1:0]           phase_sum;
  logic signed [lir_pkg::SAMPLE_W-1:0]   prev_l, prev_r, cur_l, cur_r;
  logic signed [lir_pkg::DIFF_W-1:0]     diff_l, diff_r;
  logic signed [lir_pkg::FRAC_BITS:0]    frac_ext;
  logic signed [lir_pkg::PROD_W-1:0]     prod_l, prod_r;
  logic signed [lir_pkg::PROD_W-1:0]     q_l, q_r;
  logic [lir_pkg::SAMPLE_W-1:0]          interp_l, interp_r;

  assign phase_sum = phase + {{(lir_pkg::PHASE_W-lir_pkg::STEP_W){1'b0}}, phase_step};
  assign status.phase_int_zero = (phase[lir_pkg::PHASE_W-1:lir_pkg::FRAC_BITS] == '0);
  assign status.next_int_zero  = (phase_sum[lir_pkg::PHASE_W-1:lir_pkg::FRAC_BITS] == '0);

  assign frac_ext = $signed({1'b0, phase[lir_pkg::FRAC_BITS-1:0]});

  // floor division by 2^FRAC_BITS via arithmetic shift
  assign q_l = prod_l >>> lir_pkg::FRAC_BITS;
  assign q_r = prod_r >>> lir_pkg::FRAC_BITS;
  assign interp_l = prev_l + q_l[lir_pkg::SAMPLE_W-1:0];
  assign interp_r = prev_r + q_r[lir_pkg::SAMPLE_W-1:0];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step  <= lir_pkg::STEP_RESET;
      stereo_mode <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lir_pkg::REG_PHASE_STEP:  phase_step  <= cfg_data;
        lir_pkg::REG_STEREO_MODE: stereo_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // phase and history
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= '0;
      prev_l <= '0;
      prev_r <= '0;
    end else if (cmd.flush) begin
      phase  <= '0;
      prev_l <= '0;
      prev_r <= '0;
    end else if (cmd.emit) begin
      phase <= phase_sum;
    end else if (cmd.update) begin
      if (phase >= lir_pkg::ONE_PERIOD) begin
        phase <= phase - lir_pkg::ONE_PERIOD;
      end
      prev_l <= cur_l;
      if (stereo_mode) begin
        prev_r <= cur_r;
      end
    end
  end

  // arithmetic payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_l <= left_in;
      cur_r <= right_in;
    end
    if (cmd.diff) begin
      diff_l <= {cur_l[lir_pkg::SAMPLE_W-1], cur_l} - {prev_l[lir_pkg::SAMPLE_W-1], prev_l};
      diff_r <= {cur_r[lir_pkg::SAMPLE_W-1], cur_r} - {prev_r[lir_pkg::SAMPLE_W-1], prev_r};
    end
    if (cmd.mul) begin
      prod_l <= diff_l * frac_ext;
      prod_r <= diff_r * frac_ext;
    end
    if (cmd.emit) begin
      left_out    <= interp_l;
      right_out   <= stereo_mode ? interp_r : '0;
      last_of_run <= cmd.emit_last;
    end
  end

endmodule

>>> hdl/lir_ctrl.sv
// controller: sequences one item through difference, multiply, emit and history update steps
module lir_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              opcode,
  output logic              out_valid,
  input  logic              out_ready,
  input  lir_pkg::status_t  status,
  output lir_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIFF = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  logic [2:0]                state, state_next;
  logic [lir_pkg::CNT_W-1:0] cnt;
  logic                      accept, slot_free, at_max;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign at_max    = (cnt == lir_pkg::CNT_W'(lir_pkg::MAX_OUTPUTS - 1));

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.emit_last = !status.next_int_zero || at_max;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (opcode == lir_pkg::OP_FLUSH) begin
            cmd.flush = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_next  = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = status.phase_int_zero ? S_MUL : S_UPD;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        if (slot_free) begin
          cmd.emit   = 1'b1;
          state_next = cmd.emit_last ? S_UPD : S_MUL;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.diff) begin
        cnt <= '0;
      end else if (cmd.emit) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/linear_interp_resampler.sv
// top level of the streaming linear interpolation resampler
// Stereo linear-interpolation sample rate converter with a 16.16 phase
// accumulator. Each sample item produces zero or more output items, each the
// previous sample plus frac*(cur-prev) floored by 2^16, so output lags input by
// one sample; last_of_run marks the final output of an item, and at most 64
// outputs come from one item. Mono mode (stereo_mode = 0) forces right_out to
// zero and keeps the right history. A flush item clears phase and history and
// gives no output. One item is handled at a time. A sample item holds the input
// side through a difference step, a multiply and an add/load step per output on
// one multiplier per channel, and a history update step; the add/load step waits
// while the output register is not taken. A flush item is handled in the idle
// state without leaving it. The output register lets the next item in while the
// last result of the previous one still waits. Registers are written through
// cfg_wr_en, cfg_index (0 phase_step, 1 stereo_mode) and cfg_data; the user must
// write them only while idle, which the block itself does not enforce.
module linear_interp_resampler (
  input  logic                                clk,
  input  logic                                rst,
  // configuration writes
  input  logic                                cfg_wr_en,
  input  logic [lir_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lir_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                opcode,
  input  logic signed [lir_pkg::SAMPLE_W-1:0] left_in,
  input  logic signed [lir_pkg::SAMPLE_W-1:0] right_in,
  // output items
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lir_pkg::SAMPLE_W-1:0] left_out,
  output logic signed [lir_pkg::SAMPLE_W-1:0] right_out,
  output logic                                last_of_run
);

  lir_pkg::cmd_t    cmd;
  lir_pkg::status_t status;

  // state machine: handshakes, output count, output valid
  lir_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // phase accumulator, history, interpolation and output data register
  lir_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .left_in     (left_in),
    .right_in    (right_in),
    .cmd         (cmd),
    .status      (status),
    .left_out    (left_out),
    .right_out   (right_out),
    .last_of_run (last_of_run)
  );

endmodule

>>> hdl/lir_checker.sv
// port-level checks for the resampler, bound to the top level
module lir_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                opcode,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [lir_pkg::SAMPLE_W-1:0] left_out,
  input logic signed [lir_pkg::SAMPLE_W-1:0] right_out,
  input logic                                last_of_run
);

  // reset leaves no output pending and the input side open
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("output pending or input closed after reset");

  // a sample item keeps the block busy after it is accepted
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == lir_pkg::OP_SAMPLE |=> !in_ready)
    else $error("input reopened right after a sample item");

  // a flush item finishes without closing the input side
  a_flush_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == lir_pkg::OP_FLUSH |=> in_ready)
    else $error("flush item held the input side");

  // a stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out)
      && $stable(last_of_run))
    else $error("stalled output item changed");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (.*);

>>> verif/tb_top.sv
// testbench for the linear interpolation resampler: directed and random streams
`timescale 1ns / 1ps

module tb_top;

  // run length and settling
  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_ITEMS  = 160;
  localparam int HOLD_CYCLES   = 300;       // long receiver stall for the backpressure test

  // one expected output item
  typedef struct packed {
    logic signed [lir_pkg::SAMPLE_W-1:0] left;
    logic signed [lir_pkg::SAMPLE_W-1:0] right;
    logic                                is_last;
  } stereo_out_t;

  logic                                clk;
  logic                                rst;
  logic                                cfg_wr_en;
  logic [lir_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [lir_pkg::CFG_DATA_W-1:0]      cfg_data;
  logic                                in_valid;
  logic                                in_ready;
  logic                                opcode;
  logic signed [lir_pkg::SAMPLE_W-1:0] left_in;
  logic signed [lir_pkg::SAMPLE_W-1:0] right_in;
  logic                                out_valid;
  logic                                out_ready;
  logic signed [lir_pkg::SAMPLE_W-1:0] left_out;
  logic signed [lir_pkg::SAMPLE_W-1:0] right_out;
  logic                                last_of_run;

  // predictor state, mirrors the block after reset
  logic [lir_pkg::PHASE_W-1:0]         acc_phase  = '0;
  logic signed [lir_pkg::SAMPLE_W-1:0] hist_left  = '0;
  logic signed [lir_pkg::SAMPLE_W-1:0] hist_right = '0;
  logic [lir_pkg::STEP_W-1:0]          cfg_step   = lir_pkg::STEP_RESET;
  logic                                cfg_stereo = 1'b1;

  stereo_out_t pending_outputs[$];   // interpolated items still to come out
  int          errors      = 0;
  int          cycle_count = 0;
  int          hold_cycles = 0;      // receiver holds out_ready low while nonzero
  logic        steady      = 1'b0;   // no idling on either side

  linear_interp_resampler DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .left_in     (left_in),
    .right_in    (right_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .left_out    (left_out),
    .right_out   (right_out),
    .last_of_run (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // prev + floor(frac * (cur - prev) / 2^FRAC_BITS), difference taken wide
  function automatic logic signed [lir_pkg::SAMPLE_W-1:0] lerp(
    input logic signed [lir_pkg::SAMPLE_W-1:0] prev_s,
    input logic signed [lir_pkg::SAMPLE_W-1:0] cur_s,
    input logic [lir_pkg::FRAC_BITS-1:0]       frac
  );
    logic signed [63:0] span;
    logic signed [63:0] scaled;
    logic signed [63:0] q;
    span   = {{32{cur_s[lir_pkg::SAMPLE_W-1]}}, cur_s}
           - {{32{prev_s[lir_pkg::SAMPLE_W-1]}}, prev_s};
    scaled = span * $signed({48'd0, frac});
    q      = scaled >>> lir_pkg::FRAC_BITS;
    return prev_s + q[lir_pkg::SAMPLE_W-1:0];
  endfunction

  // expected outputs of one accepted item, and the state it leaves behind
  task automatic interpolate_outputs(
    input logic                                op,
    input logic signed [lir_pkg::SAMPLE_W-1:0] cur_l,
    input logic signed [lir_pkg::SAMPLE_W-1:0] cur_r
  );
    logic [lir_pkg::PHASE_W-1:0] ph;
    logic [lir_pkg::PHASE_W-1:0] ph_next;
    stereo_out_t                 res;
    int                          n;
    if (op == lir_pkg::OP_FLUSH) begin
      acc_phase  = '0;
      hist_left  = '0;
      hist_right = '0;
    end else begin
      ph = acc_phase;
      n  = 0;
      // one output per step while the integer part of the phase is zero
      while (ph[lir_pkg::PHASE_W-1:lir_pkg::FRAC_BITS] == '0 && n < lir_pkg::MAX_OUTPUTS) begin
        ph_next     = ph + lir_pkg::PHASE_W'(cfg_step);
        res.left    = lerp(hist_left, cur_l, ph[lir_pkg::FRAC_BITS-1:0]);
        res.right   = cfg_stereo ? lerp(hist_right, cur_r, ph[lir_pkg::FRAC_BITS-1:0]) : '0;
        res.is_last = !(ph_next[lir_pkg::PHASE_W-1:lir_pkg::FRAC_BITS] == '0
                        && n + 1 < lir_pkg::MAX_OUTPUTS);
        pending_outputs.push_back(res);
        n++;
        ph = ph_next;
      end
      // drop one input period, saturating after a capped run
      if (ph >= lir_pkg::ONE_PERIOD)
        ph = ph - lir_pkg::ONE_PERIOD;
      acc_phase = ph;
      hist_left = cur_l;
      if (cfg_stereo)
        hist_right = cur_r;
    end
  endtask

  // predict on every accepted input item
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      interpolate_outputs(opcode, left_in, right_in);
  end

  // compare each accepted output item with the oldest expectation
  always @(posedge clk) begin
    stereo_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected output item, left %h right %h last %b",
                 $time, left_out, right_out, last_of_run);
        errors++;
      end else begin
        want = pending_outputs.pop_front();
        if (left_out !== want.left) begin
          $display("%0t: left_out mismatch, expected %h, actual %h",
                   $time, want.left, left_out);
          errors++;
        end
        if (right_out !== want.right) begin
          $display("%0t: right_out mismatch, expected %h, actual %h",
                   $time, want.right, right_out);
          errors++;
        end
        if (last_of_run !== want.is_last) begin
          $display("%0t: last_of_run mismatch, expected %b, actual %b",
                   $time, want.is_last, last_of_run);
          errors++;
        end
      end
    end
  end

  // mostly short gaps, now and then a long one, none in steady stretches
  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady)
      return 0;
    if (roll < 65)
      return 0;
    if (roll < 92)
      return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // receiver: random stalls plus the long hold-off on request
  initial begin
    int stall;
    stall     = 0;
    out_ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = idle_gap();
      end
      @(negedge clk);
    end
  end

  // offer one item and hold it until accepted; starts and ends at a falling edge
  task automatic send_item(
    input logic                                op,
    input logic signed [lir_pkg::SAMPLE_W-1:0] l,
    input logic signed [lir_pkg::SAMPLE_W-1:0] r
  );
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    left_in  <= l;
    right_in <= r;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // stop sending, wait for every expected item, then let the block settle
  task automatic wait_drain(input int settle);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_outputs.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  // register write, only while the block is idle
  task automatic write_reg(
    input logic [lir_pkg::CFG_IDX_W-1:0]  idx,
    input logic [lir_pkg::CFG_DATA_W-1:0] val
  );
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == lir_pkg::REG_PHASE_STEP)
      cfg_step = val;
    else
      cfg_stereo = val[0];
    @(negedge clk);
  endtask

  task automatic set_config(input logic [lir_pkg::CFG_DATA_W-1:0] step, input logic stereo);
    wait_drain(SETTLE_CYCLES);
    write_reg(lir_pkg::REG_PHASE_STEP, step);
    write_reg(lir_pkg::REG_STEREO_MODE, lir_pkg::CFG_DATA_W'(stereo));
  endtask

  function automatic logic signed [lir_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return $signed($urandom_range(0, 2000)) - 1000;
      default: return $urandom;
    endcase
  endfunction

  // reset values of the registers, full-scale swings at unit step
  task automatic test_reset_defaults();
    send_item(lir_pkg::OP_SAMPLE, 32'sh7fffffff, 32'sh80000000);
    send_item(lir_pkg::OP_SAMPLE, 32'sh80000000, 32'sh7fffffff);
    send_item(lir_pkg::OP_SAMPLE, -32'sd1, 32'sd0);
    send_item(lir_pkg::OP_SAMPLE, 32'sd0, -32'sd1);
  endtask

  // 64 outputs per item, the output cap, and a phase that stays below one period
  task automatic test_upsample_limits();
    set_config(lir_pkg::CFG_DATA_W'(1024), 1'b1);
    send_item(lir_pkg::OP_SAMPLE, 32'sh80000000, 32'sh7fffffff);
    send_item(lir_pkg::OP_SAMPLE, 32'sh7fffffff, 32'sh80000000);
    set_config(lir_pkg::CFG_DATA_W'(1000), 1'b1);
    send_item(lir_pkg::OP_SAMPLE, 32'sh12345678, -32'sh0badcafe);
    send_item(lir_pkg::OP_SAMPLE, -32'sh7654321, 32'sh00c0ffee);
    // zero step: every item runs into the cap
    set_config('0, 1'b1);
    send_item(lir_pkg::OP_SAMPLE, 32'sh55aa55aa, -32'sh2aa55aa5);
  endtask

  // items that produce nothing, largest steps, flush in the middle of a skip
  task automatic test_downsample();
    set_config(lir_pkg::CFG_DATA_W'(1048576), 1'b1);
    send_item(lir_pkg::OP_SAMPLE, 32'sh40000000, -32'sh40000000);
    send_item(lir_pkg::OP_SAMPLE, 32'sh00001111, 32'sh00002222);
    send_item(lir_pkg::OP_SAMPLE, -32'sh00003333, 32'sh00004444);
    set_config({lir_pkg::CFG_DATA_W{1'b1}}, 1'b1);
    send_item(lir_pkg::OP_SAMPLE, 32'sh0f0f0f0f, 32'shf0f0f0f0);
    send_item(lir_pkg::OP_SAMPLE, 32'sh33333333, 32'shcccccccc);
    send_item(lir_pkg::OP_FLUSH, 32'sh7fffffff, 32'sh7fffffff);
    send_item(lir_pkg::OP_SAMPLE, -32'sh00000100, 32'sh00000100);
  endtask

  // mono zeroes the right channel and keeps its history for later stereo
  task automatic test_mono_mode();
    set_config(lir_pkg::CFG_DATA_W'(40000), 1'b0);
    send_item(lir_pkg::OP_SAMPLE, 32'sh01000000, 32'sh7fff0000);
    send_item(lir_pkg::OP_SAMPLE, -32'sh01000000, -32'sh7fff0000);
    send_item(lir_pkg::OP_SAMPLE, 32'sh00abcdef, 32'sh12345678);
    set_config(lir_pkg::CFG_DATA_W'(40000), 1'b1);
    send_item(lir_pkg::OP_SAMPLE, 32'sh00000000, -32'sh40000000);
    send_item(lir_pkg::OP_SAMPLE, 32'sh10000000, 32'sh10000000);
  endtask

  // flush ignores the sample fields and clears phase and history
  task automatic test_flush();
    set_config(lir_pkg::CFG_DATA_W'(30000), 1'b1);
    send_item(lir_pkg::OP_SAMPLE, 32'sh20000000, -32'sh20000000);
    send_item(lir_pkg::OP_SAMPLE, -32'sh30000000, 32'sh30000000);
    send_item(lir_pkg::OP_FLUSH, -32'sd1, -32'sd1);
    send_item(lir_pkg::OP_SAMPLE, 32'sh7ffffff0, 32'sh80000010);
    send_item(lir_pkg::OP_FLUSH, 32'sd0, 32'sd0);
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    set_config(lir_pkg::CFG_DATA_W'(16384), 1'b1);
    hold_cycles = HOLD_CYCLES;
    repeat (12) send_item(lir_pkg::OP_SAMPLE, rand_sample(), rand_sample());
    // sender pauses until every expected item is out
    wait_drain(0);
    repeat (4) send_item(lir_pkg::OP_SAMPLE, rand_sample(), rand_sample());
  endtask

  // random configurations and sample streams, some flushes and drained pauses
  task automatic test_random_traffic();
    logic [lir_pkg::CFG_DATA_W-1:0] step;
    int                             sent;
    int                             burst;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(15, 35);
      case ($urandom_range(0, 9))
        0: begin
          step  = lir_pkg::CFG_DATA_W'($urandom_range(1024, 8191));
          burst = 6;
        end
        1: begin
          step  = {lir_pkg::CFG_DATA_W{1'b1}};
          burst = 20;
        end
        2:       step = lir_pkg::CFG_DATA_W'(1048576);
        3, 4:    step = lir_pkg::CFG_DATA_W'($urandom_range(16384, 131072));
        5:       step = lir_pkg::CFG_DATA_W'(65536);
        6:       step = lir_pkg::CFG_DATA_W'($urandom_range(131072, 1048576));
        7:       step = lir_pkg::CFG_DATA_W'($urandom_range(1024, 1048576));
        8:       step = lir_pkg::CFG_DATA_W'($urandom_range(8192, 32768));
        default: begin
          // below the useful range, down to zero
          step  = lir_pkg::CFG_DATA_W'($urandom_range(0, 1023));
          burst = 3;
        end
      endcase
      set_config(step, 1'($urandom_range(0, 1)));
      steady = ($urandom_range(0, 3) == 0);
      repeat (burst) begin
        if ($urandom_range(0, 24) == 0)
          wait_drain(0);
        if ($urandom_range(0, 19) == 0)
          send_item(lir_pkg::OP_FLUSH, $urandom, $urandom);
        else
          send_item(lir_pkg::OP_SAMPLE, rand_sample(), rand_sample());
        sent++;
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    opcode    = lir_pkg::OP_SAMPLE;
    left_in   = '0;
    right_in  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_upsample_limits();
    test_downsample();
    test_mono_mode();
    test_flush();
    test_backpressure();
    test_random_traffic();

    wait_drain(SETTLE_CYCLES);
    if (errors == 0 && pending_outputs.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
